// ----- sv/lrc_pkg.sv -----
`default_nettype none
package lrc_pkg;

	localparam int DEF_ENTRIES = 16;
	localparam int CFG_W       = 5;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int S_TDATA_W   = KEY_W + VAL_W;
	localparam int M_TDATA_W   = VAL_W;

	localparam logic [CFG_W-1:0] CAP_RESET  = CFG_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	typedef enum logic {
		ACT_GET = 1'b0,
		ACT_SET = 1'b1
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} lrc_req_t;

	typedef struct packed {
		logic              hit;
		logic [VAL_W-1:0]  value;
	} lrc_rsp_t;

endpackage
`default_nettype wire

// ----- sv/lru_cache_table.sv -----
// Requests pass an input register, then a result register. Throughput: one request per cycle
// unless a stalled result holds back a get; the table lookup and the LRU rank update finish
// between the two registers, so back-to-back requests see each other's updates.
// A get yields one result, a set yields none.
// Reset (arst_n low, asynchronous): table empty, all ranks zero, capacity 16, both stages empty.
`default_nettype none
module lru_cache_table #(
	parameter int ENTRIES = lrc_pkg::DEF_ENTRIES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Request stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [lrc_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] lookup_key, [63:32] write_value
	input  wire logic [0:0]                    s_tuser,   // [0] action (0 get, 1 set)
	// Result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [lrc_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] read_value
	output logic [0:0]                         m_tuser,   // [0] hit
	// Capacity register write
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lrc_pkg::CFG_W-1:0]     cfg_data   // capacity_in_use
);
	import lrc_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [CFG_W-1:0]   capacity_q;
	logic               valid_s1;
	lrc_req_t           req_s1;
	logic               out_valid_s2;
	lrc_rsp_t           rsp_s2;
	lrc_rsp_t           rsp;
	logic               out_free;
	logic               advance;
	logic [CNT_W-1:0]   entry_count;
	logic [ENTRIES-1:0] entry_valid;

	// Capacity register: always ready; the user must write it only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Result slot can take a new get result when empty or draining this cycle.
	assign out_free = !out_valid_s2 || m_tready;
	// A set never needs the result slot, so it always moves through.
	assign advance  = valid_s1 && ((req_s1.action == ACT_SET) || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register: hold the request until the table takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.action <= action_t'(s_tuser[0]);
			req_s1.key    <= s_tdata[KEY_W-1:0];
			req_s1.value  <= s_tdata[S_TDATA_W-1:KEY_W];
		end
	end

	// Lookup and replacement update; state advances at the edge that retires the request.
	lrc_table #(
		.ENTRIES(ENTRIES)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (capacity_q),
		.req_valid  (advance),
		.req        (req_s1),
		.rsp        (rsp),
		.entry_count(entry_count),
		.entry_valid(entry_valid)
	);

	// Result register: capture get results, hold them while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= advance && (req_s1.action == ACT_GET);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && (req_s1.action == ACT_GET)) begin
			rsp_s2 <= rsp;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = rsp_s2.value;
	assign m_tuser  = rsp_s2.hit;

	// Entry count always matches the number of valid entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(entry_valid) == int'(entry_count))
		else $error("entry count differs from valid entries");

	// Never more entries than the table holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(entry_count) <= ENTRIES)
		else $error("entry count above table size");

	// Every retired get shows up as a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1.action == ACT_GET)) |=> m_tvalid)
		else $error("get retired without a result");

	// A miss always reports the all-ones value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == MISS_VALUE))
		else $error("miss result carries a stored value");

endmodule
`default_nettype wire

// ----- sv/lrc_table.sv -----
`default_nettype none
module lrc_table #(
	parameter  int ENTRIES = lrc_pkg::DEF_ENTRIES,
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [lrc_pkg::CFG_W-1:0] capacity,
	input  wire logic                      req_valid,
	input  wire lrc_pkg::lrc_req_t         req,
	output lrc_pkg::lrc_rsp_t              rsp,
	output logic [CNT_W-1:0]               entry_count,
	output logic [ENTRIES-1:0]             entry_valid
);
	import lrc_pkg::*;

	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [KEY_W-1:0] keys_q   [ENTRIES];
	logic [VAL_W-1:0] values_q [ENTRIES];
	logic [IDX_W-1:0] rank_q   [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;

	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] victim;
	logic [ENTRIES-1:0] slot;
	logic               hit_any;
	logic [VAL_W-1:0]   hit_value;
	logic [IDX_W-1:0]   hit_rank;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   eff_cap;
	logic               full;
	logic [IDX_W-1:0]   oldest_rank;
	logic               do_get_hit;
	logic               do_set_hit;
	logic               do_insert;

	// Parallel compare of every entry against the key.
	always_comb begin
		hit_value = '0;
		hit_rank  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (keys_q[i] == req.key);
			if (hit_vec[i]) begin
				hit_value = hit_value | values_q[i];
				hit_rank  = hit_rank | rank_q[i];
			end
		end
		hit_any = |hit_vec;
	end

	// Clamp capacity to 1..ENTRIES; full means an insert must evict.
	always_comb begin
		cap_ext = CMP_W'(capacity);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		full        = CMP_W'(count_q) >= eff_cap;
		oldest_rank = IDX_W'(count_q - 1'b1);
	end

	// Victim holds the highest rank; the new entry goes to the lowest index that is free or the victim's.
	always_comb begin
		logic taken;
		taken = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			victim[i] = full && valid_q[i] && (rank_q[i] == oldest_rank);
			slot[i]   = 1'b0;
			if (!taken && (!valid_q[i] || victim[i])) begin
				slot[i] = 1'b1;
				taken   = 1'b1;
			end
		end
	end

	assign do_get_hit = req_valid && (req.action == ACT_GET) && hit_any;
	assign do_set_hit = req_valid && (req.action == ACT_SET) && hit_any;
	assign do_insert  = req_valid && (req.action == ACT_SET) && !hit_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_get_hit) begin
					if (hit_vec[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end else if (do_insert) begin
					if (slot[i]) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (victim[i]) begin
						valid_q[i] <= 1'b0;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
			if (do_insert && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (do_insert && slot[i]) begin
				keys_q[i]   <= req.key;
				values_q[i] <= req.value;
			end else if (do_set_hit && hit_vec[i]) begin
				values_q[i] <= req.value;
			end
		end
	end

	assign rsp.hit     = hit_any;
	assign rsp.value   = hit_any ? hit_value : MISS_VALUE;
	assign entry_count = count_q;
	assign entry_valid = valid_q;

endmodule
`default_nettype wire

// ----- tb/tb_lru_cache_table.sv -----
`timescale 1ns / 1ps

module tb_lru_cache_table;
	import lrc_pkg::*;

	localparam int TABLE_SLOTS = DEF_ENTRIES;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 75;
	// Two register stages; leave margin so a trailing set drains before a capacity change.
	localparam int DRAIN_CYCLES = 6;

	typedef enum logic {
		ROW_REQ = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	typedef enum int {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_t;

	// One row of the directed sequence. For ROW_CFG, arg carries the capacity.
	typedef struct packed {
		row_kind_t         kind;
		action_t           act;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  arg;
		logic              typed;
		lrc_rsp_t          rsp;
	} stim_row_t;

	localparam lrc_rsp_t NO_RSP = '0;
	localparam lrc_rsp_t MISS   = '{1'b0, MISS_VALUE};
	localparam int DIRECTED_ROWS = 30;

	// Directed walk: empty-table misses, key/value extremes, overwrite without reordering,
	// capacity dropped below the count, capacity 0 acting as 1, capacity 31 acting as 16.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_REQ, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS},
		'{ROW_REQ, ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, MISS},
		'{ROW_REQ, ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000}},
		'{ROW_REQ, ACT_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF}},
		'{ROW_REQ, ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
		'{ROW_REQ, ACT_SET, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0001}},
		'{ROW_REQ, ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_RSP},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'd2,         1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'h0000_0005, 32'h0000_0055, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'h0000_0006, 32'h0000_0066, 1'b0, NO_RSP},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'd0,         1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'h0000_0007, 32'h0000_0077, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, NO_RSP},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'd31,        1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_GET, 32'h5555_5555, 32'h0000_0000, 1'b1, MISS},
		'{ROW_REQ, ACT_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, NO_RSP},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'd1,         1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'h0000_0001, 32'h0000_0001, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_SET, 32'h0000_0002, 32'h0000_0002, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, NO_RSP},
		'{ROW_REQ, ACT_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, NO_RSP},
		'{ROW_CFG, ACT_GET, 32'h0000_0000, 32'd16,        1'b0, NO_RSP}
	};

	// Capacity per random phase; phase 5 draws its own.
	localparam logic [CFG_W-1:0] PHASE_CAP [PHASE_COUNT] = '{
		5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9, 5'd2, 5'd16
	};

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;   // [31:0] lookup_key, [63:32] write_value
	logic [0:0]           s_tuser   = '0;   // [0] action
	logic                 m_tvalid;
	logic                 m_tready  = 1'b1;
	logic [M_TDATA_W-1:0] m_tdata;          // [31:0] read_value
	logic [0:0]           m_tuser;          // [0] hit
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shadow copy of the table, updated at every accepted request transfer.
	logic [KEY_W-1:0] shadow_key [TABLE_SLOTS];
	logic [VAL_W-1:0] shadow_val [TABLE_SLOTS];
	bit               shadow_used [TABLE_SLOTS];
	int               shadow_age [TABLE_SLOTS];
	int               shadow_count;
	logic [CFG_W-1:0] shadow_capacity;

	// Expected get results, oldest first.
	lrc_rsp_t pending_lookups [$];

	int bad_results;
	int send_gap_pct;
	int recv_stall_pct;
	logic [KEY_W-1:0] key_pool [$];

	lru_cache_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drop the oldest valid entry; on equal ranks the highest slot goes.
	function automatic void shadow_evict_oldest();
		int victim;
		int worst;
		victim = -1;
		worst  = 0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (shadow_used[i] && (victim < 0 || shadow_age[i] >= worst)) begin
				victim = i;
				worst  = shadow_age[i];
			end
		end
		if (victim >= 0) begin
			shadow_used[victim] = 1'b0;
			shadow_age[victim]  = 0;
			if (shadow_count > 0)
				shadow_count--;
		end
	endfunction

	// Apply one request to the shadow table; return 1 with the expected result for a get.
	function automatic bit shadow_access(input action_t act, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val, output lrc_rsp_t rsp);
		int idx;
		int slot;
		int limit;
		idx  = -1;
		slot = -1;
		rsp  = NO_RSP;
		for (int i = 0; i < TABLE_SLOTS; i++)
			if (idx < 0 && shadow_used[i] && shadow_key[i] == key)
				idx = i;

		if (act == ACT_SET) begin
			if (idx >= 0) begin
				// overwrite in place, recency order stays
				shadow_val[idx] = val;
				return 1'b0;
			end
			// 0 acts as 1, anything above the table size acts as the table size
			limit = int'(shadow_capacity);
			if (limit < 1)
				limit = 1;
			if (limit > TABLE_SLOTS)
				limit = TABLE_SLOTS;
			if (shadow_count + 1 > limit || shadow_count >= TABLE_SLOTS)
				shadow_evict_oldest();
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (shadow_used[i])
					shadow_age[i]++;
				else if (slot < 0)
					slot = i;
			end
			if (slot >= 0) begin
				shadow_used[slot] = 1'b1;
				shadow_key[slot]  = key;
				shadow_val[slot]  = val;
				shadow_age[slot]  = 0;
				shadow_count++;
			end
			return 1'b0;
		end

		if (idx < 0) begin
			rsp = MISS;
			return 1'b1;
		end
		// promote the hit entry, age everything that was more recent
		for (int i = 0; i < TABLE_SLOTS; i++)
			if (shadow_used[i] && shadow_age[i] < shadow_age[idx])
				shadow_age[i]++;
		shadow_age[idx] = 0;
		rsp = '{1'b1, shadow_val[idx]};
		return 1'b1;
	endfunction

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			PACE_SEND_GAPS: begin
				send_gap_pct   = 52;
				recv_stall_pct = 0;
			end
			PACE_RECV_STALLS: begin
				send_gap_pct   = 0;
				recv_stall_pct = 52;
			end
			default: begin
				send_gap_pct   = 19;
				recv_stall_pct = 19;
			end
		endcase
	endtask

	// Offer one request, hold it until the transfer, then predict. Return at a falling edge
	// with tvalid still high so back-to-back requests need no second assignment.
	task automatic send_request(input action_t act, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val, input bit typed, input lrc_rsp_t typed_rsp);
		lrc_rsp_t rsp;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {val, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (shadow_access(act, key, val, rsp))
			pending_lookups.push_back(typed ? typed_rsp : rsp);
		@(negedge clk);
	endtask

	// Write capacity only with the table idle: drain results, then the pipeline.
	task automatic write_capacity(input logic [CFG_W-1:0] cap);
		s_tvalid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_capacity = cap;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Keys for one phase: a few more than fit, so gets both hit and miss on evicted keys.
	task automatic refill_key_pool(input logic [CFG_W-1:0] cap);
		int fill;
		logic [KEY_W-1:0] corner;
		fill = (cap == 0) ? 1 : (cap > TABLE_SLOTS ? TABLE_SLOTS : int'(cap));
		fill += 1 + $urandom_range(4);
		key_pool.delete();
		repeat (fill) begin
			case ($urandom_range(7))
				0: corner = 32'h0000_0000;
				1: corner = 32'hFFFF_FFFF;
				2: corner = 32'h8000_0000;
				3: corner = 32'h7FFF_FFFF;
				default: corner = $urandom;
			endcase
			key_pool.push_back(corner);
		end
	endtask

	// Receiver: decide tready for the next edge.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Check every result transfer against the oldest expectation.
	always @(posedge clk) begin
		lrc_rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lookups.size() == 0) begin
				bad_results++;
				if (bad_results <= MAX_REPORTS)
					$display("%0t: result with nothing pending, hit=%0b value=%h",
						$realtime, m_tuser[0], m_tdata);
			end else begin
				want = pending_lookups.pop_front();
				if (m_tuser[0] !== want.hit || m_tdata !== want.value) begin
					bad_results++;
					if (bad_results <= MAX_REPORTS)
						$display("%0t: lookup mismatch, expected hit=%0b value=%h, got hit=%0b value=%h",
							$realtime, want.hit, want.value, m_tuser[0], m_tdata);
				end
			end
		end
	end

	// Main sequence: reset, directed rows, then random phases across capacities and paces.
	initial begin
		logic [CFG_W-1:0] cap;
		logic [KEY_W-1:0] key;
		action_t act;
		bad_results     = 0;
		shadow_count    = 0;
		shadow_capacity = CAP_RESET;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			shadow_key[i]  = '0;
			shadow_val[i]  = '0;
			shadow_used[i] = 1'b0;
			shadow_age[i]  = 0;
		end
		set_pace(PACE_FULL);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].kind == ROW_CFG)
				write_capacity(DIRECTED[r].arg[CFG_W-1:0]);
			else
				send_request(DIRECTED[r].act, DIRECTED[r].key, DIRECTED[r].arg,
					DIRECTED[r].typed, DIRECTED[r].rsp);
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			cap = (ph == 5) ? CFG_W'($urandom_range(31)) : PHASE_CAP[ph];
			write_capacity(cap);
			set_pace(pace_t'(ph % 4));
			refill_key_pool(cap);
			repeat (PHASE_ITEMS) begin
				act = ($urandom_range(99) < 45) ? ACT_SET : ACT_GET;
				// mostly pooled keys to build real hit/evict traffic, some stray noise
				if ($urandom_range(99) < 82)
					key = key_pool[$urandom_range(key_pool.size() - 1)];
				else
					key = $urandom;
				send_request(act, key, $urandom, 1'b0, NO_RSP);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (bad_results == 0 && pending_lookups.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_400_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
